/* rtl/core/bdg_pkg.sv */
`default_nettype none

package bdg_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_SRC_WIDTH = 1024;
    localparam int DEF_MAX_SCALE     = 16;

    // largest source height in rows
    localparam int HEIGHT_LIMIT = 4096;

    localparam int NUM_CHAN   = 3;   // blue, green, red
    localparam int CHAN_W     = 8;
    localparam int ROW_SUM_W  = 12;  // one box row, up to 16 pixels
    localparam int SUM_W      = 16;  // one whole box, up to 256 pixels
    localparam int CNT_W      = 9;   // pixel count of a box, up to 256

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int         GRAY_SHIFT = 11;

    // reset values of the configuration registers
    localparam logic [10:0] RST_SRC_WIDTH  = 11'd640;
    localparam logic [12:0] RST_SRC_HEIGHT = 13'd480;
    localparam logic [4:0]  RST_SCALE_X    = 5'd1;
    localparam logic [4:0]  RST_SCALE_Y    = 5'd1;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_SCALE_X    = 2'd2,
        REG_SCALE_Y    = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

/* rtl/core/bdg_divider.sv */
`default_nettype none

// Three restoring dividers sharing one divisor, one quotient bit per cycle.
module bdg_divider
    import bdg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  divisor,
    input  wire logic [SUM_W-1:0]  dividend [NUM_CHAN],
    output logic      [CHAN_W-1:0] quotient [NUM_CHAN],
    output logic                   done
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic [SUM_W-1:0]  quo_reg [NUM_CHAN];
    logic [SUM_W-1:0]  quo_next [NUM_CHAN];
    logic [CNT_W-1:0]  rem_reg [NUM_CHAN];
    logic [CNT_W-1:0]  rem_next [NUM_CHAN];
    logic [CNT_W:0]    rem_shift [NUM_CHAN];

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        for (int i = 0; i < NUM_CHAN; i++) begin
            rem_shift[i] = {rem_reg[i], quo_reg[i][SUM_W-1]};
            quo_next[i]  = quo_reg[i];
            rem_next[i]  = rem_reg[i];
        end
        if (start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            divisor_next = divisor;
            for (int i = 0; i < NUM_CHAN; i++) begin
                quo_next[i] = dividend[i];
                rem_next[i] = '0;
            end
        end else if (busy_reg) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                if (rem_shift[i] >= {1'b0, divisor_reg}) begin
                    rem_next[i] = CNT_W'(rem_shift[i] - {1'b0, divisor_reg});
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = rem_shift[i][CNT_W-1:0];
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b0};
                end
            end
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg <= divisor_next;
        for (int i = 0; i < NUM_CHAN; i++) begin
            quo_reg[i] <= quo_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            quotient[i] = quo_reg[i][CHAN_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/box_downscale_to_gray_top.sv */
`default_nettype none

// Box-filter downscaler with RGB to gray conversion.
// Input channel (s_*): one packed source pixel per item in raster order,
//   red 23:16, green 15:8, blue 7:0. Result channel (m_*): one gray byte per
//   destination pixel with its column, row and a last-of-frame flag.
// APB port: src_width @0x0, src_height @0x4, scale_x @0x8, scale_y @0xC.
//   Any write restarts the frame at source column 0, row 0. Write only idle.
// Throughput: one item per cycle, except after the item that closes a box on
//   its last row: input stalls while the 16-step shared quotient unit runs,
//   then for the gray stage and output load. It waits longer only if the output
//   register is still full at that point.
// Result path: quotient unit, gray stage, then the output register.
// Column partial sums live in a 1-port-write, 1-port-read RAM; the next
//   column entry is prefetched every cycle, with write-to-read forwarding.
// Reset: registers return to 640x480, scale 1x1; frame position clears.
//   The RAM is not cleared; the first row of every box writes its entry.
// Receiver stall: a finished result sits in the output register while new
//   items keep flowing; only the next box result waits for the slot.

module box_downscale_to_gray_top
    import bdg_pkg::*;
#(
    parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SCALE     = DEF_MAX_SCALE
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // source pixels
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_pixel_word,
    // gray results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_gray_level,
    output logic [9:0]       m_out_column,
    output logic [11:0]      m_out_row,
    output logic             m_frame_done
);

    localparam int COL_W = $clog2(MAX_SRC_WIDTH);
    localparam int OFF_W = $clog2(MAX_SCALE);

    localparam logic [12:0] MAX_W_C = 13'(MAX_SRC_WIDTH);
    localparam logic [12:0] MAX_H_C = 13'(HEIGHT_LIMIT);
    localparam logic [4:0]  MAX_S_C = 5'(MAX_SCALE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // taking pixels
        ST_DIV  = 3'b010,   // averaging a finished box
        ST_OUT  = 3'b100    // waiting for the output slot
    } state_t;

    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]     col_sum_t;
    typedef logic [NUM_CHAN-1:0][ROW_SUM_W-1:0] row_sum_t;

    // ---------------- configuration registers ----------------
    logic [10:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [4:0]  scale_x_reg;
    logic [4:0]  scale_y_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            scale_x_reg    <= RST_SCALE_X;
            scale_y_reg    <= RST_SCALE_Y;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[10:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[12:0];
                REG_SCALE_X:    scale_x_reg    <= pwdata[4:0];
                REG_SCALE_Y:    scale_y_reg    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            REG_SCALE_X:    prdata = 32'(scale_x_reg);
            REG_SCALE_Y:    prdata = 32'(scale_y_reg);
            default:        prdata = '0;
        endcase
    end

    // effective sizes: zero acts as one, oversize saturates
    logic [12:0] w_eff, h_eff;
    logic [4:0]  sx_eff, sy_eff, sx_m1, sy_m1;
    logic [CNT_W-1:0] box_cnt;

    always_comb begin
        if (src_width_reg == '0)                 w_eff = 13'd1;
        else if (13'(src_width_reg) > MAX_W_C)   w_eff = MAX_W_C;
        else                                     w_eff = 13'(src_width_reg);

        if (src_height_reg == '0)                h_eff = 13'd1;
        else if (src_height_reg > MAX_H_C)       h_eff = MAX_H_C;
        else                                     h_eff = src_height_reg;

        if (scale_x_reg == '0)                   sx_eff = 5'd1;
        else if (scale_x_reg > MAX_S_C)          sx_eff = MAX_S_C;
        else                                     sx_eff = scale_x_reg;

        if (scale_y_reg == '0)                   sy_eff = 5'd1;
        else if (scale_y_reg > MAX_S_C)          sy_eff = MAX_S_C;
        else                                     sy_eff = scale_y_reg;
    end

    assign sx_m1   = sx_eff - 5'd1;
    assign sy_m1   = sy_eff - 5'd1;
    assign box_cnt = CNT_W'(CNT_W'(sx_eff) * CNT_W'(sy_eff));

    // ---------------- position and row-sum state ----------------
    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [11:0]      row_reg, row_next;
    logic [OFF_W-1:0] off_x_reg, off_x_next;
    logic [OFF_W-1:0] off_y_reg, off_y_next;
    logic [12:0]      bx_start_reg, bx_start_next;   // first column of current box
    logic [12:0]      by_start_reg, by_start_next;   // first row of current box row
    logic [COL_W-1:0] dc_reg, dc_next;               // destination column
    logic [11:0]      dr_reg, dr_next;               // destination row
    row_sum_t         rsum_reg, rsum_next;

    // pending result fields, held while the quotients are formed
    logic [9:0]       pend_col_reg, pend_col_next;
    logic [11:0]      pend_row_reg, pend_row_next;
    logic             pend_last_reg, pend_last_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       gray_reg;
    logic [9:0]       ocol_reg;
    logic [11:0]      orow_reg;
    logic             olast_reg;
    logic             out_load;

    // column-sum RAM
    col_sum_t         col_sum_mem [MAX_SRC_WIDTH];
    col_sum_t         rd_data_reg;
    col_sum_t         wr_data;
    logic             wr_en;

    logic             take;
    logic             fit_x, fit_y, last_x, last_y, in_region;
    logic             row_end, frame_end, box_done, emit;
    logic [CHAN_W-1:0] pix [NUM_CHAN];
    row_sum_t         rsum_add;

    logic             div_start, div_done;
    logic [SUM_W-1:0] div_in [NUM_CHAN];
    logic [CHAN_W-1:0] div_q [NUM_CHAN];
    logic [9:0]       avg_sum;
    logic [19:0]      gray_prod;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid & s_ready;

    // box placement tests, no division needed
    assign fit_x  = ({1'b0, bx_start_reg} + 14'(sx_eff)) <= {1'b0, w_eff};
    assign fit_y  = ({1'b0, by_start_reg} + 14'(sy_eff)) <= {1'b0, h_eff};
    assign last_x = ({1'b0, bx_start_reg} + 14'({sx_eff, 1'b0})) > {1'b0, w_eff};
    assign last_y = ({1'b0, by_start_reg} + 14'({sy_eff, 1'b0})) > {1'b0, h_eff};
    assign in_region = fit_x & fit_y;

    assign row_end   = 13'(col_reg) >= (w_eff - 13'd1);
    assign frame_end = {1'b0, row_reg} >= (h_eff - 13'd1);
    assign box_done  = take & in_region & (5'(off_x_reg) == sx_m1);
    assign emit      = box_done & (5'(off_y_reg) == sy_m1);

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            pix[i]      = s_pixel_word[CHAN_W*i +: CHAN_W];
            rsum_add[i] = rsum_reg[i] + ROW_SUM_W'(pix[i]);
            if (off_y_reg != '0) begin
                wr_data[i] = SUM_W'(rsum_add[i]) + rd_data_reg[i];
            end else begin
                wr_data[i] = SUM_W'(rsum_add[i]);
            end
        end
    end

    assign wr_en = box_done;

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        bx_start_next  = bx_start_reg;
        by_start_next  = by_start_reg;
        dc_next        = dc_reg;
        dr_next        = dr_reg;
        rsum_next      = rsum_reg;
        pend_col_next  = pend_col_reg;
        pend_row_next  = pend_row_reg;
        pend_last_next = pend_last_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;

        if (cfg_wr) begin
            // any register write restarts the frame
            col_next      = '0;
            row_next      = '0;
            off_x_next    = '0;
            off_y_next    = '0;
            bx_start_next = '0;
            by_start_next = '0;
            dc_next       = '0;
            dr_next       = '0;
            rsum_next     = '0;
        end else if (take) begin
            if (in_region) begin
                if (box_done) begin
                    rsum_next     = '0;
                    off_x_next    = '0;
                    bx_start_next = 13'(col_reg) + 13'd1;
                    dc_next       = dc_reg + 1'b1;
                end else begin
                    rsum_next  = rsum_add;
                    off_x_next = off_x_reg + 1'b1;
                end
            end
            if (emit) begin
                div_start      = 1'b1;
                pend_col_next  = 10'(dc_reg);
                pend_row_next  = dr_reg;
                pend_last_next = last_x & last_y;
                state_next     = ST_DIV;
            end

            if (row_end) begin
                col_next      = '0;
                off_x_next    = '0;
                rsum_next     = '0;
                bx_start_next = '0;
                dc_next       = '0;
                if (frame_end) begin
                    row_next      = '0;
                    off_y_next    = '0;
                    by_start_next = '0;
                    dr_next       = '0;
                end else begin
                    row_next = row_reg + 12'd1;
                    if (5'(off_y_reg) >= sy_m1) begin
                        off_y_next    = '0;
                        by_start_next = 13'(row_reg) + 13'd1;
                        dr_next       = dr_reg + 12'd1;
                    end else begin
                        off_y_next = off_y_reg + 1'b1;
                    end
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: ;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            bx_start_reg <= '0;
            by_start_reg <= '0;
            dc_reg       <= '0;
            dr_reg       <= '0;
            rsum_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            off_x_reg    <= off_x_next;
            off_y_reg    <= off_y_next;
            bx_start_reg <= bx_start_next;
            by_start_reg <= by_start_next;
            dc_reg       <= dc_next;
            dr_reg       <= dr_next;
            rsum_reg     <= rsum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_col_reg  <= pend_col_next;
        pend_row_reg  <= pend_row_next;
        pend_last_reg <= pend_last_next;
        if (out_load) begin
            gray_reg  <= gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];
            ocol_reg  <= pend_col_reg;
            orow_reg  <= pend_row_reg;
            olast_reg <= pend_last_reg;
        end
    end

    // column-sum RAM: write the closed box, prefetch the next column,
    // forward the write when both hit the same entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            col_sum_mem[dc_reg] <= wr_data;
        end
        if (wr_en && (dc_reg == dc_next)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= col_sum_mem[dc_next];
        end
    end

    // ---------------- averaging ----------------
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            div_in[i] = wr_data[i];
        end
    end

    bdg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (box_cnt),
        .dividend (div_in),
        .quotient (div_q),
        .done     (div_done)
    );

    // gray = floor(sum of averages / 3) by reciprocal multiply
    assign avg_sum   = 10'(div_q[0]) + 10'(div_q[1]) + 10'(div_q[2]);
    assign gray_prod = 20'(avg_sum) * 20'(GRAY_RECIP);

    assign m_valid      = m_valid_reg;
    assign m_gray_level = gray_reg;
    assign m_out_column = ocol_reg;
    assign m_out_row    = orow_reg;
    assign m_frame_done = olast_reg;

endmodule

`default_nettype wire

/* verif/tb_box_downscale_to_gray_top.sv */
`timescale 1ns / 100ps

module tb_box_downscale_to_gray_top;
    import bdg_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYCLES = 40;        // extra wait once the queues have drained
    localparam int LONG_HOLD     = 400;       // receiver hold-off, in cycles
    localparam int RUN_LIMIT_NS  = 4_000_000; // watchdog limit, well past the slowest run
    localparam int REPORT_MAX    = 10;

    // how the two sides idle during a phase
    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

    typedef struct packed {
        logic [7:0]  gray_level;
        logic [9:0]  out_column;
        logic [11:0] out_row;
        logic        frame_done;
    } gray_result_t;

    // ports; every input starts at a known value
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [31:0] s_pixel_word = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_gray_level;
    logic [9:0]  m_out_column;
    logic [11:0] m_out_row;
    logic        m_frame_done;

    // stimulus and scoreboard
    logic [31:0]  pixel_queue[$];
    gray_result_t gray_expect_q[$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    logic         hold_toggle    = 1'b0;
    logic         hold_ack       = 1'b0;
    int           hold_left      = 0;

    // shadow of the configuration registers, reset values
    logic [10:0] cfg_src_width  = RST_SRC_WIDTH;
    logic [12:0] cfg_src_height = RST_SRC_HEIGHT;
    logic [4:0]  cfg_scale_x    = RST_SCALE_X;
    logic [4:0]  cfg_scale_y    = RST_SCALE_Y;

    // predicted datapath state
    logic [47:0] col_sums [DEF_MAX_SRC_WIDTH];  // R 47:32, G 31:16, B 15:0
    logic [35:0] row_acc     = '0;              // R 35:24, G 23:12, B 11:0
    logic [9:0]  src_col     = '0;
    logic [11:0] src_row     = '0;
    logic [3:0]  box_col_ofs = '0;
    logic [3:0]  box_row_ofs = '0;

    // corner-case pixels: all zero, all ones, each channel alone, junk top byte
    logic [31:0] corner_pixels [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
        32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FFFF, 32'h0001_0203,
        32'h00FE_FEFE, 32'hA5FF_00FF, 32'h0000_0001, 32'h0080_8080
    };

    box_downscale_to_gray_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_word (s_pixel_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gray_level (m_gray_level),
        .m_out_column (m_out_column),
        .m_out_row    (m_out_row),
        .m_frame_done (m_frame_done)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // zero maps to one, anything past the limit to the limit
    function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Box-sum predictor: one accepted pixel in, zero or one gray result out.
    task automatic accumulate_pixel(input logic [31:0] px);
        int unsigned  w, h, sx, sy, dst_w, dst_h, cnt, dc, dr, avg_sum;
        logic [11:0]  rs, gs, bs;
        logic [15:0]  cr, cg, cb;
        gray_result_t res;
        w     = limit_to(cfg_src_width, DEF_MAX_SRC_WIDTH);
        h     = limit_to(cfg_src_height, HEIGHT_LIMIT);
        sx    = limit_to(cfg_scale_x, DEF_MAX_SCALE);
        sy    = limit_to(cfg_scale_y, DEF_MAX_SCALE);
        dst_w = w / sx;
        dst_h = h / sy;

        // leftover columns and rows past the last whole box are dropped
        if (src_col < dst_w * sx && src_row < dst_h * sy) begin
            rs = row_acc[35:24] + px[23:16];
            gs = row_acc[23:12] + px[15:8];
            bs = row_acc[11:0]  + px[7:0];
            row_acc = {rs, gs, bs};
            if (box_col_ofs == sx - 1) begin
                dc = (src_col / sx) % DEF_MAX_SRC_WIDTH;
                cr = 16'(rs);
                cg = 16'(gs);
                cb = 16'(bs);
                // first box row starts the column sum, later rows add on
                if (box_row_ofs != 0) begin
                    cr = cr + col_sums[dc][47:32];
                    cg = cg + col_sums[dc][31:16];
                    cb = cb + col_sums[dc][15:0];
                end
                col_sums[dc] = {cr, cg, cb};
                row_acc = '0;
                if (box_row_ofs == sy - 1) begin
                    cnt     = sx * sy;
                    avg_sum = cr / cnt + cg / cnt + cb / cnt;
                    dr      = src_row / sy;
                    res.gray_level = 8'(avg_sum / 3);
                    res.out_column = 10'(dc);
                    res.out_row    = 12'(dr);
                    res.frame_done = (dc == dst_w - 1 && dr == dst_h - 1);
                    gray_expect_q.push_back(res);
                end
                box_col_ofs = '0;
            end else begin
                box_col_ofs++;
            end
        end

        // raster advance with frame wrap
        if (src_col >= w - 1) begin
            src_col     = '0;
            box_col_ofs = '0;
            row_acc     = '0;
            if (src_row >= h - 1) begin
                src_row     = '0;
                box_row_ofs = '0;
            end else begin
                src_row++;
                box_row_ofs = (box_row_ofs >= sy - 1) ? 4'd0 : box_row_ofs + 4'd1;
            end
        end else begin
            src_col++;
        end
    endtask

    // APB write: setup, access, then back to idle. Any write restarts the frame.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);  // register takes the write at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cfg_src_width  = value[10:0];
            REG_SRC_HEIGHT: cfg_src_height = value[12:0];
            REG_SCALE_X:    cfg_scale_x    = value[4:0];
            REG_SCALE_Y:    cfg_scale_y    = value[4:0];
        endcase
        row_acc     = '0;
        src_col     = '0;
        src_row     = '0;
        box_col_ofs = '0;
        box_row_ofs = '0;
        @(negedge aclk);
    endtask

    task automatic configure(input int unsigned w, h, sx, sy);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
    endtask

    task automatic set_flow(input flow_t f);
        src_idle_pct   = (f == FLOW_SRC_IDLE)   ? 61 : (f == FLOW_BOTH) ? 8 : 0;
        sink_stall_pct = (f == FLOW_SINK_STALL) ? 61 : (f == FLOW_BOTH) ? 8 : 0;
    endtask

    // all items sent, all results back, then let any box still in flight settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_valid || gray_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // one configuration, random pixels; now and then a corner pixel
    task automatic run_phase(input int unsigned w, h, sx, sy, input flow_t f,
                             input int n_items);
        configure(w, h, sx, sy);
        set_flow(f);
        repeat (n_items) begin
            if ($urandom_range(7) == 0)
                pixel_queue.push_back(corner_pixels[$urandom_range(11)]);
            else
                pixel_queue.push_back($urandom());
        end
        wait_drained();
    endtask

    task automatic note_mismatch(input string why, input gray_result_t want,
                                 input gray_result_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch (%s): exp gray %0d col %0d row %0d last %0b, got gray %0d col %0d row %0d last %0b",
                     why, want.gray_level, want.out_column, want.out_row, want.frame_done,
                     seen.gray_level, seen.out_column, seen.out_row, seen.frame_done);
    endtask

    // Pixel driver: present the next queued item once the current one is taken,
    // and predict each item at the edge that accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                accumulate_pixel(s_pixel_word);
            if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid      <= 1'b1;
                s_pixel_word <= pixel_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ack != hold_toggle) begin
            hold_ack  = hold_toggle;
            hold_left = LONG_HOLD;
            m_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result monitor: compare each accepted item with the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        gray_result_t seen, want;
        if (aresetn && m_valid && m_ready) begin
            seen.gray_level = m_gray_level;
            seen.out_column = m_out_column;
            seen.out_row    = m_out_row;
            seen.frame_done = m_frame_done;
            if (gray_expect_q.size() == 0) begin
                note_mismatch("unexpected", '0, seen);
            end else begin
                want = gray_expect_q.pop_front();
                if (want.gray_level !== seen.gray_level || want.out_column !== seen.out_column
                    || want.out_row !== seen.out_row || want.frame_done !== seen.frame_done)
                    note_mismatch("field", want, seen);
            end
        end
    end

    initial begin
        foreach (col_sums[i]) col_sums[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting (640x480, 1x1): every pixel is its own box
        set_flow(FLOW_FREE);
        foreach (corner_pixels[i]) pixel_queue.push_back(corner_pixels[i]);
        wait_drained();

        // zero size and zero scale: 1x1 frame, every pixel ends a frame
        configure(0, 0, 0, 0);
        for (int i = 0; i < 6; i++) pixel_queue.push_back(corner_pixels[i]);
        wait_drained();

        // box larger than the image: destination is empty, nothing comes out
        configure(1, 1, 16, 16);
        for (int i = 6; i < 11; i++) pixel_queue.push_back(corner_pixels[i]);
        wait_drained();

        // random frames, with and without leftover columns and rows
        run_phase(8, 6, 2, 2, FLOW_FREE, 130);
        run_phase(7, 7, 3, 2, FLOW_SRC_IDLE, 130);
        run_phase(5, 9, 1, 4, FLOW_SINK_STALL, 100);
        // oversized width and scale_x clamp to 1024 and 16
        run_phase(2047, 1, 31, 1, FLOW_BOTH, 70);
        // widest row: 64 boxes across, frame ends and wraps
        run_phase(1024, 1, 16, 1, FLOW_SRC_IDLE, 1040);
        // tallest frame with tallest boxes
        run_phase(4, 4096, 4, 16, FLOW_SINK_STALL, 64);
        // oversized height, zero scale_y
        run_phase(3, 8191, 3, 0, FLOW_BOTH, 45);

        // back-pressure: receiver holds off while every pixel closes a box,
        // so the output slot fills and the input stalls
        configure(16, 16, 1, 1);
        set_flow(FLOW_FREE);
        repeat (120) pixel_queue.push_back($urandom());
        hold_toggle = ~hold_toggle;
        wait_drained();

        // largest box with saturated channels, sums near the 16-bit limit
        configure(16, 16, 16, 16);
        set_flow(FLOW_SINK_STALL);
        repeat (256) pixel_queue.push_back({8'($urandom_range(255)), 24'hFF_FFFF});
        wait_drained();

        if (mismatch_count == 0 && gray_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
